// ----- sv/idet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// idet_pkg
// Shared widths and types of the integer matrix determinant block.
// ---------------------------------------------------------------------------
package idet_pkg;
  localparam int MAX_ORDER  = 8;
  localparam int ORD_W      = 4;
  localparam int ELEM_W     = 7;
  localparam int DET_W      = 64;
  localparam int ELEM_DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int ELEM_AW    = $clog2(ELEM_DEPTH);
  localparam int SUB_DEPTH  = 2 ** MAX_ORDER;
  localparam int SUB_AW     = MAX_ORDER;
  localparam int COL_W      = $clog2(MAX_ORDER);
  localparam int CNT_W      = ELEM_AW + 1;

  typedef struct packed {
    logic clear;
    logic en;
    logic sub;
    logic unit_minor;
  } mac_ctrl_t;
endpackage
`default_nettype wire

// ----- sv/idet_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// idet_ram
// Generic simple dual-port RAM with a registered read.
// ---------------------------------------------------------------------------
module idet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/idet_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// idet_mac
// Shared multiply-accumulate unit: adds or subtracts element times minor.
// ---------------------------------------------------------------------------
module idet_mac (
  input  wire logic                             clk,
  input  wire idet_pkg::mac_ctrl_t              ctrl,
  input  wire logic [idet_pkg::ELEM_W-1:0]      elem,
  input  wire logic [idet_pkg::DET_W-1:0]       minor,
  output logic      [idet_pkg::DET_W-1:0]       acc
);
  import idet_pkg::*;

  logic [DET_W-1:0] acc_r, acc_nxt;
  logic [DET_W-1:0] minor_x, prod;

  // A seven-bit by 64-bit product; only the low 64 bits are kept.
  assign minor_x = ctrl.unit_minor ? DET_W'(1) : minor;
  assign prod    = DET_W'($signed(elem) * $signed(minor_x));

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.en) begin
      acc_nxt = ctrl.sub ? acc_r - prod : acc_r + prod;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule
`default_nettype wire

// ----- sv/integer_matrix_determinant.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: elements load one per cycle; no element is taken during the pass.
// Minors are kept per column subset in a 256-entry RAM, with no clearing pass.
// Reset (rst_n low, synchronous) sets order 3, empties the load and the output.
// ---------------------------------------------------------------------------
// integer_matrix_determinant
// Exact determinant by first-row cofactor expansion over column subsets.
// ---------------------------------------------------------------------------
module integer_matrix_determinant (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [idet_pkg::ORD_W-1:0] cfg_wdata,  // matrix_order
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [6:0] element_value
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [idet_pkg::DET_W-1:0]      out_tdata   // [63:0] determinant
);
  import idet_pkg::*;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_SETS = 6'b000010,
    ST_RD   = 6'b000100,
    ST_MAC  = 6'b001000,
    ST_WR   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [ORD_W-1:0] order_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUB_AW-1:0] set_r, set_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] row_r, row_nxt;
  logic             pos_r, pos_nxt;
  logic             unit_r, unit_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [DET_W-1:0] odata_r, odata_nxt;

  logic [ORD_W-1:0] n;
  logic [CNT_W-1:0] total;
  logic [SUB_AW-1:0] full_mask, col_bit;
  logic [COL_W-1:0] last_col;
  logic [ORD_W-1:0] pop;
  logic             in_beat;

  logic [ELEM_AW-1:0] e_raddr;
  logic [ELEM_W-1:0]  e_rdata;
  logic [SUB_AW-1:0]  d_raddr;
  logic [DET_W-1:0]   d_rdata, acc;
  mac_ctrl_t          mac_ctrl;

  always_comb begin
    if (order_r == '0) begin
      n = ORD_W'(1);
    end else if (order_r > ORD_W'(MAX_ORDER)) begin
      n = ORD_W'(MAX_ORDER);
    end else begin
      n = order_r;
    end
  end

  assign total     = CNT_W'(n) * CNT_W'(n);
  assign full_mask = SUB_AW'((SUB_DEPTH - 1) >> (MAX_ORDER - int'(n)));
  assign last_col  = COL_W'(n - ORD_W'(1));
  assign col_bit   = SUB_AW'(1) << col_r;
  assign in_tready = (state_r == ST_LOAD);
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    pop = '0;
    for (int i = 0; i < SUB_AW; i++) begin
      pop = pop + ORD_W'(set_r[i]);
    end
  end

  assign e_raddr = ELEM_AW'(row_r) * ELEM_AW'(n) + ELEM_AW'(col_r);
  assign d_raddr = set_r & ~col_bit;

  idet_ram #(.WIDTH(ELEM_W), .DEPTH(ELEM_DEPTH)) u_elem_ram (
    .clk   (clk),
    .we    (in_beat),
    .waddr (cnt_r[ELEM_AW-1:0]),
    .wdata (in_tdata[ELEM_W-1:0]),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // Minor of the bottom rows, indexed by the set of columns it keeps.
  idet_ram #(.WIDTH(DET_W), .DEPTH(SUB_DEPTH)) u_minor_ram (
    .clk   (clk),
    .we    (state_r == ST_WR),
    .waddr (set_r),
    .wdata (acc),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  assign mac_ctrl.clear      = (state_r == ST_SETS);
  assign mac_ctrl.en         = (state_r == ST_MAC);
  assign mac_ctrl.sub        = pos_r;
  assign mac_ctrl.unit_minor = unit_r;

  idet_mac u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .elem  (e_rdata),
    .minor (d_rdata),
    .acc   (acc)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    set_nxt    = set_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    pos_nxt    = pos_r;
    unit_nxt   = unit_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (out_tvalid && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_LOAD: begin
        if (in_beat) begin
          if (cnt_r + CNT_W'(1) >= total) begin
            cnt_nxt   = '0;
            set_nxt   = SUB_AW'(1);
            state_nxt = ST_SETS;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_SETS: begin
        row_nxt   = COL_W'(n - pop);
        col_nxt   = '0;
        pos_nxt   = 1'b0;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        if ((set_r & col_bit) != '0) begin
          unit_nxt  = (d_raddr == '0);
          state_nxt = ST_MAC;
        end else if (col_r == last_col) begin
          state_nxt = ST_WR;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      ST_MAC: begin
        pos_nxt = ~pos_r;
        if (col_r == last_col) begin
          state_nxt = ST_WR;
        end else begin
          col_nxt   = col_r + COL_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_WR: begin
        if (set_r == full_mask) begin
          state_nxt = ST_FIN;
        end else begin
          set_nxt   = set_r + SUB_AW'(1);
          state_nxt = ST_SETS;
        end
      end
      ST_FIN: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = acc;
          state_nxt  = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
    // A new order discards a partly loaded matrix.
    if (cfg_we) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      order_r  <= ORD_W'(3);
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    set_r   <= set_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    pos_r   <= pos_nxt;
    unit_r  <= unit_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule
`default_nettype wire

// ----- sv/idet_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// idet_checker
// Port-level checks on the determinant block, bound to the top level.
// ---------------------------------------------------------------------------
module idet_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [idet_pkg::DET_W-1:0] out_tdata
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat present after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // A result is produced only at the end of a pass, while loading is closed.
  a_rose_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while loading");
endmodule

bind integer_matrix_determinant idet_checker u_idet_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ----- verif/integer_matrix_determinant_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_matrix_determinant_checker
// Watches the element and determinant streams, predicts each determinant
// from the loaded elements and compares it with the result beat.
// ---------------------------------------------------------------------------
module integer_matrix_determinant_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [idet_pkg::ORD_W-1:0] cfg_wdata,
  input  wire logic                       in_tvalid,
  input  wire logic                       in_tready,
  input  wire logic [7:0]                 in_tdata,
  input  wire logic                       out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic [idet_pkg::DET_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              dets_pending
);
  import idet_pkg::*;

  logic signed [DET_W-1:0] det_queue[$];
  logic signed [DET_W-1:0] elems[ELEM_DEPTH];
  logic [ORD_W-1:0]        order_reg;
  int                      loaded;

  function automatic int eff_order(logic [ORD_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_ORDER) return MAX_ORDER;
    return int'(r);
  endfunction

  // First-row cofactor expansion over the remaining column set.
  function automatic logic signed [DET_W-1:0] cofactor_det(int n, int row, int cols);
    logic signed [DET_W-1:0] sum;
    logic signed [DET_W-1:0] term;
    int pos;
    sum = 0;
    pos = 0;
    for (int c = 0; c < n; c++) begin
      if (cols[c]) begin
        term = elems[row * n + c];
        if (row + 1 < n)
          term = term * cofactor_det(n, row + 1, cols & ~(1 << c));
        if (pos[0]) sum = sum - term;
        else sum = sum + term;
        pos++;
      end
    end
    return sum;
  endfunction

  always @(posedge clk) begin
    int n;
    logic signed [DET_W-1:0] want;
    if (!rst_n) begin
      order_reg  <= 4'd3;
      loaded     = 0;
      fail_count <= 0;
      det_queue.delete();
      dets_pending <= 0;
    end else begin
      n = eff_order(order_reg);
      if (cfg_we) begin
        order_reg <= cfg_wdata;
        loaded = 0;
      end else if (in_tvalid && in_tready) begin
        elems[loaded] = DET_W'(signed'(in_tdata[ELEM_W-1:0]));
        loaded++;
        if (loaded == n * n) begin
          det_queue.push_back(cofactor_det(n, 0, (1 << n) - 1));
          loaded = 0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (det_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected determinant beat %0d", $signed(out_tdata));
          fail_count <= fail_count + 1;
        end else begin
          want = det_queue.pop_front();
          if (want !== out_tdata) begin
            if (fail_count < 10)
              $display("determinant mismatch: expected %0d, got %0d",
                       want, $signed(out_tdata));
            fail_count <= fail_count + 1;
          end
        end
      end
      dets_pending <= det_queue.size();
    end
  end
endmodule

// ----- verif/integer_matrix_determinant_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_matrix_determinant_tb
// Loads matrices of every order, directed and random, under varying stream
// back-pressure, and checks every determinant through the checker.
// ---------------------------------------------------------------------------
module integer_matrix_determinant_tb;
  import idet_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [ORD_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [DET_W-1:0] out_tdata;
  int               fail_count;
  int               dets_pending;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               elems_sent = 0;

  always #2 clk = ~clk;

  integer_matrix_determinant u_top (.*);

  integer_matrix_determinant_checker u_chk (.*);

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The valid stays high between back-to-back beats and drops only while idling.
  task automatic send_elem(logic [ELEM_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    elems_sent++;
  endtask

  // Stops sending and waits until every predicted determinant has arrived.
  task automatic drain_dets();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (dets_pending != 0) @(posedge clk);
  endtask

  task automatic set_order(logic [ORD_W-1:0] ord);
    drain_dets();
    cfg_we    <= 1'b1;
    cfg_wdata <= ord;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(5))
      0: return 7'h40;
      1: return 7'h3f;
      2: return 7'h00;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic send_matrix(int n);
    for (int i = 0; i < n * n; i++) send_elem(rand_elem());
  endtask

  function automatic int small_order();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 1);
  endfunction

  initial begin
    int ord;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset order 3 with extreme elements.
    for (int i = 0; i < 9; i++) send_elem((i % 2) ? 7'h40 : 7'h3f);
    // Order zero behaves as order one.
    set_order(4'd0);
    send_elem(7'h40);
    send_elem(7'h3f);
    // Order above the maximum saturates: one all-minimum matrix of order 8.
    set_order(4'd15);
    for (int i = 0; i < 64; i++) send_elem(7'h40);
    // A write during a load discards the partial matrix.
    set_order(4'd2);
    send_elem(7'h15);
    send_elem(7'h2a);
    set_order(4'd2);
    for (int i = 0; i < 4; i++) send_elem(i[0] ? 7'h55 : 7'h2a);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 63 : 0;
      recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 14 : 0;
      while (elems_sent < 580 * (ph + 1)) begin
        ord = small_order();
        set_order(4'(ord));
        repeat ($urandom_range(6, 1)) send_matrix(ord);
      end
    end
    set_order(4'd8);
    send_matrix(8);
    set_order(4'd1);
    send_elem(7'h7f);
    drain_dets();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
